>>> hdl/ufc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ufc_pkg
// Shared types and constants of the UDP header filter and counter.
// ---------------------------------------------------------------------------
package ufc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 65536;

  localparam logic [7:0]  UDP_PROTO  = 8'd17;
  localparam logic [7:0]  ETH_HDR    = 8'd14;
  localparam logic [7:0]  UDP_HDR    = 8'd8;
  localparam logic [4:0]  MIN_FRAME  = 5'd24;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [16:0] PORT_ANY   = 17'h1FFFF;

  typedef enum logic [1:0] {
    ST_NOT_UDP   = 2'd0,
    ST_FILTERED  = 2'd1,
    ST_ACCEPTED  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_SRC_ADDR_ON  = 3'd0,
    CFG_SRC_ADDR     = 3'd1,
    CFG_DST_ADDR_ON  = 3'd2,
    CFG_DST_ADDR     = 3'd3,
    CFG_SRC_PORT     = 3'd4,
    CFG_DST_PORT     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] seen_src_addr;
    logic [31:0] seen_dst_addr;
    logic [15:0] seen_src_port;
    logic [15:0] seen_dst_port;
    logic [15:0] datagram_length;
    logic [31:0] accepted_packets;
    logic [31:0] accepted_bytes;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_item_t;

  // capture state of the frame including the byte in flight
  typedef struct packed {
    logic [3:0]  hdr_words;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_len;
    logic [16:0] frame_len;
  } frame_t;

  function automatic logic port_ok(input logic [16:0] filt, input logic [15:0] port);
    logic ok;
    if (filt == PORT_ANY) begin
      ok = 1'b1;
    end else if (filt[16]) begin
      ok = 1'b0;
    end else begin
      ok = (filt[15:0] == port);
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ufc_chan_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ufc_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface ufc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/ufc_capture.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ufc_capture
// Byte position tracking and header field capture of the current frame.
// ---------------------------------------------------------------------------
module ufc_capture #(
  parameter int MAX_FRAME_BYTES = ufc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output ufc_pkg::frame_t      frame_o
);

  localparam logic [16:0] MaxBytes = 17'(MAX_FRAME_BYTES);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  hdr_q;
  logic [7:0]  proto_q;
  logic [31:0] src_addr_q, dst_addr_q;
  logic [15:0] src_port_q, dst_port_q, udp_len_q;

  logic        in_range;
  logic [7:0]  base;
  logic [15:0] port_off;
  logic        in_ports;
  logic [16:0] len_raw;

  always_comb begin
    in_range = ({1'b0, pos_q} < MaxBytes);
    base     = ufc_pkg::ETH_HDR + {2'b00, hdr_q, 2'b00};
    port_off = pos_q - {8'h00, base};
    in_ports = in_range && (hdr_q >= ufc_pkg::MIN_HDR_WORDS) && (pos_q > 16'd14) &&
               (pos_q >= {8'h00, base}) && (port_off < 16'd6);

    frame_o.hdr_words = hdr_q;
    frame_o.protocol  = proto_q;
    frame_o.src_addr  = src_addr_q;
    frame_o.dst_addr  = dst_addr_q;
    frame_o.src_port  = src_port_q;
    frame_o.dst_port  = dst_port_q;
    frame_o.udp_len   = udp_len_q;

    if (in_range) begin
      if (pos_q == 16'd14) begin
        frame_o.hdr_words = byte_i[3:0];
      end else if (pos_q == 16'd23) begin
        frame_o.protocol = byte_i;
      end else if (pos_q >= 16'd26 && pos_q <= 16'd29) begin
        frame_o.src_addr = {src_addr_q[23:0], byte_i};
      end else if (pos_q >= 16'd30 && pos_q <= 16'd33) begin
        frame_o.dst_addr = {dst_addr_q[23:0], byte_i};
      end
    end

    if (in_ports) begin
      if (port_off < 16'd2) begin
        frame_o.src_port = {src_port_q[7:0], byte_i};
      end else if (port_off < 16'd4) begin
        frame_o.dst_port = {dst_port_q[7:0], byte_i};
      end else begin
        frame_o.udp_len = {udp_len_q[7:0], byte_i};
      end
    end

    len_raw = {1'b0, pos_q} + 17'd1;
    frame_o.frame_len = (len_raw > MaxBytes) ? MaxBytes : len_raw;

    if (last_i) begin
      pos_d = '0;
    end else if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_q      <= '0;
      proto_q    <= '0;
      src_addr_q <= '0;
      dst_addr_q <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      udp_len_q  <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      if (last_i) begin
        hdr_q      <= '0;
        proto_q    <= '0;
        src_addr_q <= '0;
        dst_addr_q <= '0;
        src_port_q <= '0;
        dst_port_q <= '0;
        udp_len_q  <= '0;
      end else begin
        hdr_q      <= frame_o.hdr_words;
        proto_q    <= frame_o.protocol;
        src_addr_q <= frame_o.src_addr;
        dst_addr_q <= frame_o.dst_addr;
        src_port_q <= frame_o.src_port;
        dst_port_q <= frame_o.dst_port;
        udp_len_q  <= frame_o.udp_len;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/udp_header_filter_counter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// udp_header_filter_counter
// Per-byte UDP header capture, address/port filter and saturating counters.
// ---------------------------------------------------------------------------
// Throughput: one frame byte per cycle, sustained, with no gaps between frames, while the result is not stalled.
// Result path: the input register takes a frame's last byte at the transfer, then
//   capture/classify writes the frame's result into the result register.
// A stalled result holds the last-byte stage; other bytes keep flowing.
// Reset: asynchronous, active low; clears capture state, totals and filters
//   (address matching off, both port filters set to any port).
module udp_header_filter_counter #(
  parameter int MAX_FRAME_BYTES = ufc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ufc_chan_if.sink    in_i,
  ufc_chan_if.sink    cfg_i,
  ufc_chan_if.source  res_o
);

  // configuration
  logic        src_on_q, dst_on_q;
  logic [31:0] src_val_q, dst_val_q;
  logic [16:0] src_pf_q, dst_pf_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_on_q  <= 1'b0;
      src_val_q <= '0;
      dst_on_q  <= 1'b0;
      dst_val_q <= '0;
      src_pf_q  <= ufc_pkg::PORT_ANY;
      dst_pf_q  <= ufc_pkg::PORT_ANY;
    end else if (cfg_i.valid) begin
      case (ufc_pkg::cfg_idx_e'(cfg_i.data.index))
        ufc_pkg::CFG_SRC_ADDR_ON: src_on_q  <= cfg_i.data.value[0];
        ufc_pkg::CFG_SRC_ADDR:    src_val_q <= cfg_i.data.value;
        ufc_pkg::CFG_DST_ADDR_ON: dst_on_q  <= cfg_i.data.value[0];
        ufc_pkg::CFG_DST_ADDR:    dst_val_q <= cfg_i.data.value;
        ufc_pkg::CFG_SRC_PORT:    src_pf_q  <= cfg_i.data.value[16:0];
        ufc_pkg::CFG_DST_PORT:    dst_pf_q  <= cfg_i.data.value[16:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q;
  logic       out_free;
  logic       step;

  assign out_free   = !out_valid_q || res_o.ready;
  assign step       = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data.frame_byte;
      s1_last_q <= in_i.data.frame_last;
    end
  end

  ufc_pkg::frame_t frame;

  ufc_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .frame_o (frame)
  );

  // classify
  logic [31:0]      pkts_q, pkts_d;
  logic [31:0]      bytes_q, bytes_d;
  logic [6:0]       need_len;
  logic             match;
  logic [32:0]      byte_add;
  ufc_pkg::status_e status;

  always_comb begin
    need_len = 7'(ufc_pkg::ETH_HDR) + 7'(ufc_pkg::UDP_HDR) + {1'b0, frame.hdr_words, 2'b00};
    match    = (!src_on_q || frame.src_addr == src_val_q) &&
               (!dst_on_q || frame.dst_addr == dst_val_q) &&
               ufc_pkg::port_ok(src_pf_q, frame.src_port) &&
               ufc_pkg::port_ok(dst_pf_q, frame.dst_port);
    byte_add = {1'b0, bytes_q} + {17'h00000, frame.udp_len};
    pkts_d   = pkts_q;
    bytes_d  = bytes_q;

    if (frame.frame_len < {12'h000, ufc_pkg::MIN_FRAME}) begin
      status = ufc_pkg::ST_MALFORMED;
    end else if (frame.protocol != ufc_pkg::UDP_PROTO) begin
      status = ufc_pkg::ST_NOT_UDP;
    end else if (frame.hdr_words < ufc_pkg::MIN_HDR_WORDS ||
                 frame.frame_len < {10'h000, need_len}) begin
      status = ufc_pkg::ST_MALFORMED;
    end else if (match) begin
      status = ufc_pkg::ST_ACCEPTED;
      if (pkts_q != 32'hFFFF_FFFF) begin
        pkts_d = pkts_q + 32'd1;
      end
      bytes_d = byte_add[32] ? 32'hFFFF_FFFF : byte_add[31:0];
    end else begin
      status = ufc_pkg::ST_FILTERED;
    end
  end

  // result register
  ufc_pkg::out_item_t res_q;
  logic               emit;

  assign emit = step && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pkts_q      <= '0;
      bytes_q     <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        pkts_q      <= pkts_d;
        bytes_q     <= bytes_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q.frame_status     <= status;
      res_q.seen_src_addr    <= frame.src_addr;
      res_q.seen_dst_addr    <= frame.dst_addr;
      res_q.seen_src_port    <= frame.src_port;
      res_q.seen_dst_port    <= frame.dst_port;
      res_q.datagram_length  <= frame.udp_len;
      res_q.accepted_packets <= pkts_d;
      res_q.accepted_bytes   <= bytes_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

endmodule
`default_nettype wire
